### hw/rtl/rbvi_pkg.sv
// Shared types, constants and helpers of the rigid body velocity integrator.
`default_nettype none
package rbvi_pkg;

  localparam int unsigned CfgW   = 31;
  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // input kind codes
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_FORCE  = 2'd1;
  localparam logic [1:0] KIND_TORQUE = 2'd2;

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_MASS  = 3'd0;
  localparam logic [IdxW-1:0] REG_FRIC  = 3'd1;
  localparam logic [IdxW-1:0] REG_LDRAG = 3'd2;
  localparam logic [IdxW-1:0] REG_ADRAG = 3'd3;
  localparam logic [IdxW-1:0] REG_GRAV  = 3'd4;
  localparam logic [IdxW-1:0] REG_DT    = 3'd5;

  localparam logic [CfgW-1:0] MASS_RST = 31'd65536;
  localparam logic [CfgW-1:0] DT_RST   = 31'd1092;
  localparam logic [63:0]     REST_SQ  = 64'd429497;
  localparam logic [16:0]     QONE     = 17'h10000;

  // classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_TICK,
    OP_FORCE,
    OP_TORQUE
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic                    on_ground;
    logic signed [DataW-1:0] vx;
    logic signed [DataW-1:0] vy;
    logic signed [DataW-1:0] vz;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0] mass;
    logic [CfgW-1:0] fric;
    logic [CfgW-1:0] ldrag;
    logic [CfgW-1:0] adrag;
    logic            grav;
    logic [CfgW-1:0] dt;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  // magnitude of a signed word, 2^31 included
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rbvi_ifs.sv
// Request channel interfaces of the velocity integrator.
`default_nettype none
interface rbvi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic               on_ground;
  modport source (output valid, kind, vec_x, vec_y, vec_z, on_ground, input ready);
  modport sink   (input valid, kind, vec_x, vec_y, vec_z, on_ground, output ready);
endinterface

interface rbvi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic signed [31:0] move_z;
  logic signed [31:0] turn_x;
  logic signed [31:0] turn_y;
  logic signed [31:0] turn_z;
  logic signed [31:0] vel_out_x;
  logic signed [31:0] vel_out_y;
  logic signed [31:0] vel_out_z;
  modport source (output valid, move_x, move_y, move_z, turn_x, turn_y, turn_z,
                  vel_out_x, vel_out_y, vel_out_z, input ready);
  modport sink   (input valid, move_x, move_y, move_z, turn_x, turn_y, turn_z,
                  vel_out_x, vel_out_y, vel_out_z, output ready);
endinterface
`default_nettype wire

### hw/rtl/rbvi_front.sv
// Front end: takes requests, drops unknown kinds, classifies the rest.
`default_nettype none
module rbvi_front import rbvi_pkg::*; (
  rbvi_in_if.sink in_ch,
  input  logic    q_full,
  output logic    q_push,
  output item_t   q_item
);

  logic keep;
  op_t  op;

  // decode the request kind
  always_comb begin
    keep = 1'b1;
    op   = OP_TICK;
    case (in_ch.kind)
      KIND_TICK:   op = OP_TICK;
      KIND_FORCE:  op = OP_FORCE;
      KIND_TORQUE: op = OP_TORQUE;
      default:     keep = 1'b0;
    endcase
  end

  assign in_ch.ready      = !q_full;
  assign q_push           = in_ch.valid && !q_full && keep;
  assign q_item.op        = op;
  assign q_item.on_ground = in_ch.on_ground;
  assign q_item.vx        = in_ch.vec_x;
  assign q_item.vy        = in_ch.vec_y;
  assign q_item.vz        = in_ch.vec_z;

endmodule
`default_nettype wire

### hw/rtl/rbvi_fifo.sv
// Short queue between front and back end.
`default_nettype none
module rbvi_fifo import rbvi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t pop_item
);

  item_t            ent_r [QDepth];
  logic [QPtrW-1:0] wr_r;
  logic [QPtrW-1:0] rd_r;
  logic [QCntW-1:0] cnt_r;

  assign full     = (cnt_r == QCntW'(QDepth));
  assign valid    = (cnt_r != '0);
  assign pop_item = ent_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == QPtrW'(QDepth - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == QPtrW'(QDepth - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_item;
  end

endmodule
`default_nettype wire

### hw/rtl/rbvi_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
`default_nettype none
module rbvi_div import rbvi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] rem_r;
  logic [63:0] quo_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] sh;
  logic [32:0] diff;
  logic        ge;

  // one shift-subtract step
  assign sh   = {rem_r, quo_r[63]};
  assign diff = sh - {1'b0, dvs_r};
  assign ge   = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : sh[31:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

### hw/rtl/rbvi_back.sv
// Back end: sequencer over one multiplier, the divider and a square root.
`default_nettype none
module rbvi_back import rbvi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  item_t    q_item,
  output logic     q_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  rbvi_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_DIVW,
    S_FT_OP, S_FT_DIV, S_FT_ADD,
    S_GRAV,
    S_FR_SQ, S_FR_ACC, S_FR_D, S_SQRT, S_FR_CHK, S_FR_OP, S_FR_DIV, S_FR_SUB,
    S_DRAG_Q, S_DRAG_F, S_DRAG_OP, S_DRAG_APP,
    S_REST_SQ, S_REST_ACC, S_REST_CHK,
    S_OUT_OP, S_OUT_APP, S_EMIT
  } state_t;

  state_t             state_r, ret_r;
  logic signed [31:0] lv_r  [3];
  logic signed [31:0] sv_r  [3];
  logic signed [31:0] vec_r [3];
  logic signed [31:0] om_r  [3];
  logic signed [31:0] ot_r  [3];
  logic signed [31:0] ov_r  [3];
  logic signed [31:0] mv_r  [3];
  logic signed [31:0] tn_r  [3];
  logic               gnd_r;
  logic [1:0]         i_r;
  logic               dsel_r;
  logic               neg_r;
  logic [31:0]        ma_r, mb_r;
  logic [63:0]        prod_r;
  logic [63:0]        acc_r;
  logic [53:0]        d_r;
  logic [16:0]        fac_r;
  logic [63:0]        rem_r, root_r, bit_r;
  logic               out_valid_r;
  logic               div_start_r;
  logic [63:0]        div_dnd_r;
  logic [31:0]        div_dvs_r;

  logic signed [31:0] cur_v;
  logic signed [65:0] q_sgn;
  logic signed [31:0] add_res, sub_res, scl_res, grav_res;
  logic [47:0]        pq;
  logic [53:0]        d_calc;
  logic [16:0]        fac_calc;
  logic [36:0]        g50;
  logic [63:0]        trial;
  logic               sq_ge;

  function automatic logic signed [65:0] ext66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [65:0] sgn66(input logic neg, input logic [63:0] mag);
    logic signed [65:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

  // operand select and per-step arithmetic
  assign cur_v    = dsel_r ? sv_r[i_r] : lv_r[i_r];
  assign q_sgn    = sgn66(neg_r, div_rsp.quotient);
  assign add_res  = sat66(ext66(cur_v) + q_sgn);
  assign sub_res  = sat66(ext66(cur_v) - q_sgn);
  assign pq       = prod_r[63:16];
  assign scl_res  = sat66(sgn66(neg_r, {16'b0, pq}));
  assign d_calc   = {1'b0, pq, 5'b0} + {2'b0, pq, 4'b0} + {5'b0, pq, 1'b0};
  assign fac_calc = (pq < 48'd65536) ? 17'(QONE - {1'b0, pq[15:0]}) : 17'd0;
  assign g50      = {1'b0, cfg.dt, 5'b0} + {2'b0, cfg.dt, 4'b0} + {5'b0, cfg.dt, 1'b0};
  assign grav_res = sat66(ext66(lv_r[1]) - $signed({29'b0, g50}));
  assign trial    = root_r + bit_r;
  assign sq_ge    = (rem_r >= trial);

  assign q_pop            = (state_r == S_IDLE) && q_valid;
  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dnd_r;
  assign div_req.divisor  = div_dvs_r;

  // sequencer, velocity state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        lv_r[k] <= '0;
        sv_r[k] <= '0;
      end
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            vec_r[0] <= q_item.vx;
            vec_r[1] <= q_item.vy;
            vec_r[2] <= q_item.vz;
            gnd_r    <= q_item.on_ground;
            i_r      <= 2'd0;
            dsel_r   <= (q_item.op == OP_TORQUE);
            case (q_item.op)
              OP_TICK:   state_r <= S_GRAV;
              OP_FORCE,
              OP_TORQUE: state_r <= (cfg.mass != '0) ? S_FT_OP : S_IDLE;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= ma_r * mb_r;
          state_r <= ret_r;
        end
        S_DIVW: begin
          if (div_rsp.done) state_r <= ret_r;
        end
        // force or torque: v += f*dt/m
        S_FT_OP: begin
          ma_r    <= abs32(vec_r[i_r]);
          mb_r    <= {1'b0, cfg.dt};
          neg_r   <= vec_r[i_r][31];
          ret_r   <= S_FT_DIV;
          state_r <= S_MUL;
        end
        S_FT_DIV: begin
          div_start_r <= 1'b1;
          div_dnd_r   <= prod_r;
          div_dvs_r   <= {1'b0, cfg.mass};
          ret_r       <= S_FT_ADD;
          state_r     <= S_DIVW;
        end
        S_FT_ADD: begin
          if (dsel_r) sv_r[i_r] <= add_res;
          else        lv_r[i_r] <= add_res;
          if (i_r == 2'd2) state_r <= S_IDLE;
          else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_FT_OP;
          end
        end
        // gravity, then friction when grounded with mass
        S_GRAV: begin
          if (cfg.grav && !gnd_r) lv_r[1] <= grav_res;
          dsel_r <= 1'b0;
          i_r    <= 2'd0;
          acc_r  <= '0;
          if (gnd_r && cfg.mass != '0) state_r <= S_FR_SQ;
          else                         state_r <= S_DRAG_Q;
        end
        S_FR_SQ: begin
          ma_r    <= abs32(lv_r[i_r]);
          mb_r    <= abs32(lv_r[i_r]);
          ret_r   <= S_FR_ACC;
          state_r <= S_MUL;
        end
        S_FR_ACC: begin
          acc_r <= acc_r + prod_r;
          if (i_r == 2'd0) begin
            i_r     <= 2'd2;
            state_r <= S_FR_SQ;
          end else begin
            ma_r    <= {1'b0, cfg.fric};
            mb_r    <= {1'b0, cfg.dt};
            ret_r   <= S_FR_D;
            state_r <= S_MUL;
          end
        end
        S_FR_D: begin
          d_r     <= d_calc;
          rem_r   <= acc_r;
          root_r  <= '0;
          bit_r   <= 64'd1 << 62;
          state_r <= S_SQRT;
        end
        // integer square root, two bits of radicand a cycle
        S_SQRT: begin
          if (sq_ge) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= S_FR_CHK;
        end
        S_FR_CHK: begin
          i_r <= 2'd0;
          if (root_r[31:0] == '0) state_r <= S_DRAG_Q;
          else if (d_r >= {22'b0, root_r[31:0]}) begin
            lv_r[0] <= '0;
            lv_r[2] <= '0;
            state_r <= S_DRAG_Q;
          end else state_r <= S_FR_OP;
        end
        S_FR_OP: begin
          ma_r    <= abs32(lv_r[i_r]);
          mb_r    <= d_r[31:0];
          neg_r   <= lv_r[i_r][31];
          ret_r   <= S_FR_DIV;
          state_r <= S_MUL;
        end
        S_FR_DIV: begin
          div_start_r <= 1'b1;
          div_dnd_r   <= prod_r;
          div_dvs_r   <= root_r[31:0];
          ret_r       <= S_FR_SUB;
          state_r     <= S_DIVW;
        end
        S_FR_SUB: begin
          lv_r[i_r] <= sub_res;
          if (i_r == 2'd0) begin
            i_r     <= 2'd2;
            state_r <= S_FR_OP;
          end else state_r <= S_DRAG_Q;
        end
        // drag: linear set first, then spin
        S_DRAG_Q: begin
          ma_r    <= {1'b0, dsel_r ? cfg.adrag : cfg.ldrag};
          mb_r    <= {1'b0, cfg.dt};
          ret_r   <= S_DRAG_F;
          state_r <= S_MUL;
        end
        S_DRAG_F: begin
          fac_r   <= fac_calc;
          i_r     <= 2'd0;
          state_r <= S_DRAG_OP;
        end
        S_DRAG_OP: begin
          ma_r    <= abs32(cur_v);
          mb_r    <= {15'b0, fac_r};
          neg_r   <= cur_v[31];
          ret_r   <= S_DRAG_APP;
          state_r <= S_MUL;
        end
        S_DRAG_APP: begin
          if (dsel_r) sv_r[i_r] <= scl_res;
          else        lv_r[i_r] <= scl_res;
          if (i_r != 2'd2) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_DRAG_OP;
          end else if (!dsel_r) begin
            dsel_r  <= 1'b1;
            state_r <= S_DRAG_Q;
          end else begin
            dsel_r  <= 1'b0;
            i_r     <= 2'd0;
            acc_r   <= '0;
            state_r <= S_REST_SQ;
          end
        end
        // rest threshold on the squared speed
        S_REST_SQ: begin
          ma_r    <= abs32(lv_r[i_r]);
          mb_r    <= abs32(lv_r[i_r]);
          ret_r   <= S_REST_ACC;
          state_r <= S_MUL;
        end
        S_REST_ACC: begin
          acc_r <= acc_r + prod_r;
          if (i_r == 2'd2) state_r <= S_REST_CHK;
          else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_REST_SQ;
          end
        end
        S_REST_CHK: begin
          if (acc_r < REST_SQ) begin
            for (int k = 0; k < 3; k++) lv_r[k] <= '0;
          end
          i_r     <= 2'd0;
          dsel_r  <= 1'b0;
          state_r <= S_OUT_OP;
        end
        // deltas: velocity times dt
        S_OUT_OP: begin
          ma_r    <= abs32(cur_v);
          mb_r    <= {1'b0, cfg.dt};
          neg_r   <= cur_v[31];
          ret_r   <= S_OUT_APP;
          state_r <= S_MUL;
        end
        S_OUT_APP: begin
          if (dsel_r) tn_r[i_r] <= scl_res;
          else        mv_r[i_r] <= scl_res;
          if (i_r != 2'd2) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_OUT_OP;
          end else if (!dsel_r) begin
            dsel_r  <= 1'b1;
            i_r     <= 2'd0;
            state_r <= S_OUT_OP;
          end else state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              om_r[k] <= mv_r[k];
              ot_r[k] <= tn_r[k];
              ov_r[k] <= lv_r[k];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.move_x    = om_r[0];
  assign out_ch.move_y    = om_r[1];
  assign out_ch.move_z    = om_r[2];
  assign out_ch.turn_x    = ot_r[0];
  assign out_ch.turn_y    = ot_r[1];
  assign out_ch.turn_z    = ot_r[2];
  assign out_ch.vel_out_x = ov_r[0];
  assign out_ch.vel_out_y = ov_r[1];
  assign out_ch.vel_out_z = ov_r[2];

endmodule
`default_nettype wire

### hw/rtl/rigid_body_velocity_integrator.sv
// Rigid body velocity integrator top level: config registers and unit wiring.
//
// Requests enter on in_ch (valid/ready): kind 0 is a tick, 1 adds a force,
// 2 adds a torque, 3 is dropped. Each tick returns one result on out_ch with
// the position and rotation deltas and the new linear velocity; force and
// torque requests return nothing.
// cfg_we/cfg_idx/cfg_data write one register per cycle; the user must write
// only while idle, as the block does not enforce it. A front end classifies
// requests into a two-entry queue; the back end works one request at a time
// over a shared 32x32 multiplier, a one-bit-a-cycle 64/32 divider and a
// two-bits-a-cycle square root. Force and torque requests each take three
// 64-step divisions; a tick with ground friction adds a square root and at
// most two divisions.
// Reset (synchronous, rst_n low) clears both velocities, empties the queue
// and loads the register defaults. A stalled receiver holds the result in the
// output register; the back end keeps taking force and torque requests and
// waits only when the next tick result is ready.
`default_nettype none
module rigid_body_velocity_integrator import rbvi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  rbvi_in_if.sink         in_ch,
  rbvi_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_idx,
  input  logic [CfgW-1:0] cfg_data
);

  cfg_t     cfg_r;
  logic     q_full, q_push, q_pop, q_valid;
  item_t    push_item, pop_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mass  <= MASS_RST;
      cfg_r.fric  <= '0;
      cfg_r.ldrag <= '0;
      cfg_r.adrag <= '0;
      cfg_r.grav  <= 1'b1;
      cfg_r.dt    <= DT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MASS:  cfg_r.mass  <= cfg_data;
        REG_FRIC:  cfg_r.fric  <= cfg_data;
        REG_LDRAG: cfg_r.ldrag <= cfg_data;
        REG_ADRAG: cfg_r.adrag <= cfg_data;
        REG_GRAV:  cfg_r.grav  <= cfg_data[0];
        REG_DT:    cfg_r.dt    <= cfg_data;
        default:   ;
      endcase
    end
  end

  rbvi_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  rbvi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  rbvi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rbvi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
